[src/ir_uart_8o1_run_length_decoder_macros.svh]
// assertion macros for the checker file of the run-length decoder
`ifndef IR_UART_8O1_RUN_LENGTH_DECODER_MACROS_SVH
`define IR_UART_8O1_RUN_LENGTH_DECODER_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define IRDEC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is high
`define IRDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/irdec_pkg.sv]
// shared types and constants of the run-length uart decoder
package irdec_pkg;

   // register reset values and limits
   localparam logic [15:0] IRDEC_BIT_TIME_RESET     = 16'd417;
   localparam logic [15:0] IRDEC_BUFFER_LIMIT_RESET = 16'd256;
   localparam int unsigned IRDEC_QUEUE_DEPTH        = 2;

   // register indexes, taken from address bit 2
   localparam logic REG_BIT_TIME     = 1'b0;
   localparam logic REG_BUFFER_LIMIT = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_BYTE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   // burst result codes
   localparam logic [1:0] BURST_OK    = 2'd0;
   localparam logic [1:0] BURST_ERROR = 2'd1;
   localparam logic [1:0] BURST_FULL  = 2'd2;

   // one queued run, already classified as mark or space
   typedef struct packed {
      logic        mark;
      logic [23:0] duration;
      logic        last;
   } run_type;

endpackage

[src/irdec_front.sv]
// front end: accepts runs, classifies the level and queues them
module irdec_front #(
   parameter int unsigned QUEUE_DEPTH = irdec_pkg::IRDEC_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_pulse_flag,
   input  logic [23:0]        req_duration,
   input  logic               req_last_in_burst,
   output logic               q_valid,
   output irdec_pkg::run_type q_data,
   input  logic               q_pop
);
   import irdec_pkg::*;

   // depth of at least two
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   run_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   run_type          entry;

   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_data    = queue_ff[rd_ptr_ff];

   // space when the pulse flag is set
   always_comb begin
      entry.mark     = ~req_pulse_flag;
      entry.duration = req_duration;
      entry.last     = req_last_in_burst;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

[src/irdec_back.sv]
// back end: serial divide to bit count, frame stepping, burst tracking, result register
module irdec_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        bit_time,
   input  logic [15:0]        buffer_limit,
   input  logic               q_valid,
   input  irdec_pkg::run_type q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_rx_byte,
   output logic               rsp_burst_end,
   output logic [1:0]         rsp_burst_result,
   output logic [15:0]        rsp_byte_count
);
   import irdec_pkg::*;

   localparam logic [4:0] DIV_STEPS  = 5'd25;
   localparam logic [3:0] MAX_BITS   = 4'd10;
   localparam logic [3:0] POS_IDLE   = 4'd0;
   localparam logic [3:0] POS_PARITY = 4'd9;
   localparam logic [3:0] POS_STOP   = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CLAMP,
      ST_STEP,
      ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic        mark_ff, mark_in;
   logic        last_ff, last_in;
   logic [24:0] num_ff, num_in;
   logic [15:0] rem_ff, rem_in;
   logic [24:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  bits_ff, bits_in;
   logic        err_ff, err_in;
   logic        got_ff, got_in;
   logic [7:0]  rx_ff, rx_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  shift_ff, shift_in;
   logic        par_ff, par_in;
   logic        err_seen_ff, err_seen_in;
   logic        ovf_ff, ovf_in;
   logic [15:0] bytes_ff, bytes_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_rx_ff, rsp_rx_in;
   logic        rsp_end_ff, rsp_end_in;
   logic [1:0]  rsp_result_ff, rsp_result_in;
   logic [15:0] rsp_count_ff, rsp_count_in;

   logic [15:0] per;
   logic [16:0] trial;
   logic        ovf_now;
   logic        par_next;
   logic        err_seen_next;
   logic [1:0]  status_next;
   logic [15:0] bytes_next;

   // zero period acts as one microsecond
   assign per     = (bit_time == 16'd0) ? 16'd1 : bit_time;
   assign trial   = {rem_ff, num_ff[24]};
   assign ovf_now = ovf_ff || (bytes_ff >= buffer_limit);
   assign q_pop   = (state_ff == ST_IDLE) && q_valid;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_rx_byte      = rsp_rx_ff;
   assign rsp_burst_end    = rsp_end_ff;
   assign rsp_burst_result = rsp_result_ff;
   assign rsp_byte_count   = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      mark_in       = mark_ff;
      last_in       = last_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      bits_in       = bits_ff;
      err_in        = err_ff;
      got_in        = got_ff;
      rx_in         = rx_ff;
      pos_in        = pos_ff;
      shift_in      = shift_ff;
      par_in        = par_ff;
      err_seen_in   = err_seen_ff;
      ovf_in        = ovf_ff;
      bytes_in      = bytes_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_rx_in     = rsp_rx_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_result_in = rsp_result_ff;
      rsp_count_in  = rsp_count_ff;
      par_next      = par_ff ^ mark_ff;
      err_seen_next = err_seen_ff | err_ff;

      if (ovf_ff) begin
         status_next = STATUS_NONE;
      end else if (err_ff) begin
         status_next = STATUS_ERROR;
      end else if (got_ff) begin
         status_next = STATUS_BYTE;
      end else begin
         status_next = STATUS_NONE;
      end
      bytes_next = (status_next == STATUS_BYTE) ? 16'(bytes_ff + 16'd1) : bytes_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               mark_in = q_data.mark;
               last_in = q_data.last;
               err_in  = 1'b0;
               got_in  = 1'b0;
               rx_in   = 8'd0;
               ovf_in  = ovf_now;
               num_in  = {1'b0, q_data.duration} + {9'd0, 1'b0, per[15:1]};
               rem_in  = 16'd0;
               quo_in  = 25'd0;
               cnt_in  = 5'd0;
               state_in = ovf_now ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            // one restoring divide step per cycle
            if (trial >= {1'b0, per}) begin
               rem_in = 16'(trial - {1'b0, per});
               quo_in = {quo_ff[23:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[23:0], 1'b0};
            end
            num_in = {num_ff[23:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_STEPS - 5'd1) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (quo_ff > {21'd0, MAX_BITS}) begin
               if (mark_ff) begin
                  bits_in = MAX_BITS;
               end else begin
                  // break: restart the frame, the run is one start bit
                  err_in   = 1'b1;
                  pos_in   = POS_IDLE;
                  shift_in = 8'd0;
                  par_in   = 1'b0;
                  bits_in  = 4'd1;
               end
            end else begin
               bits_in = quo_ff[3:0];
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (bits_ff == 4'd0) begin
               state_in = ST_DONE;
            end else begin
               bits_in = bits_ff - 4'd1;
               if (pos_ff == POS_IDLE) begin
                  if (!mark_ff) begin
                     pos_in   = 4'd1;
                     shift_in = 8'd0;
                     par_in   = 1'b0;
                  end
               end else if (pos_ff < POS_PARITY) begin
                  pos_in   = pos_ff + 4'd1;
                  shift_in = {mark_ff, shift_ff[7:1]};
                  par_in   = par_next;
               end else if (pos_ff == POS_PARITY) begin
                  pos_in = POS_STOP;
                  rx_in  = shift_ff;
                  got_in = 1'b1;
                  par_in = par_next;
                  if (!par_next) begin
                     err_in = 1'b1;
                  end
               end else begin
                  // stop bit must be mark
                  if (!mark_ff) begin
                     err_in = 1'b1;
                  end
                  pos_in = POS_IDLE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_next;
               rsp_rx_in     = rx_ff;
               rsp_end_in    = last_ff;
               rsp_count_in  = bytes_next;
               if (!last_ff) begin
                  rsp_result_in = BURST_OK;
               end else if (ovf_ff) begin
                  rsp_result_in = BURST_FULL;
               end else if (err_seen_next) begin
                  rsp_result_in = BURST_ERROR;
               end else begin
                  rsp_result_in = BURST_OK;
               end
               if (last_ff) begin
                  err_seen_in = 1'b0;
                  ovf_in      = 1'b0;
                  bytes_in    = 16'd0;
               end else begin
                  err_seen_in = err_seen_next;
                  bytes_in    = bytes_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_IDLE;
         shift_ff     <= 8'd0;
         par_ff       <= 1'b0;
         err_seen_ff  <= 1'b0;
         ovf_ff       <= 1'b0;
         bytes_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         shift_ff      <= shift_in;
         par_ff        <= par_in;
         err_seen_ff   <= err_seen_in;
         ovf_ff        <= ovf_in;
         bytes_ff      <= bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
         mark_ff       <= mark_in;
         last_ff       <= last_in;
         num_ff        <= num_in;
         rem_ff        <= rem_in;
         quo_ff        <= quo_in;
         cnt_ff        <= cnt_in;
         bits_ff       <= bits_in;
         err_ff        <= err_in;
         got_ff        <= got_in;
         rx_ff         <= rx_in;
         rsp_status_ff <= rsp_status_in;
         rsp_rx_ff     <= rsp_rx_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_result_ff <= rsp_result_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

endmodule

[src/ir_uart_8o1_run_length_decoder.sv]
// top level of the run-length 8o1 uart decoder with its register port
// usage:
//   req_ channel: one beat per level run (pulse flag set = space, 24-bit
//     duration in microseconds, last-in-burst marker); req_stall is high
//     while the run queue is full
//   rsp_ channel: exactly one result beat per run, held in an output
//     register until taken; rsp_stall only holds that register, the queue
//     keeps taking runs until it fills
//   register port: bit time at 0x0, buffer_limit at 0x4, to be written by
//     the user only while the decoder is idle (unenforced); pready is always high
// sequencing:
//   a run that is decoded passes through the back end as a pop, 25
//   restoring divide steps, a clamp, bits + 1 frame steps and a result;
//   the serial divider is the longest of these steps
//   a run of a burst that is already full skips from pop to result
//   a run that finds the back end idle is popped the cycle after accept
// reset: synchronous; registers go to 417 and 256, the frame waits for a
//   start bit, burst counters clear, queue and result register empty
module ir_uart_8o1_run_length_decoder #(
   parameter int unsigned QUEUE_DEPTH = irdec_pkg::IRDEC_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // run input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pulse_flag,
   input  logic [23:0] req_duration,
   input  logic        req_last_in_burst,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_burst_end,
   output logic [1:0]  rsp_burst_result,
   output logic [15:0] rsp_byte_count,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import irdec_pkg::*;

   logic [15:0] bit_time_ff;
   logic [15:0] buffer_limit_ff;
   logic        csr_write;
   logic        q_valid;
   logic        q_pop;
   run_type     q_data;

   // register port: word index from address bit 2, low bits ignored
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_BUFFER_LIMIT) ? {16'd0, buffer_limit_ff}
                                                      : {16'd0, bit_time_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff     <= IRDEC_BIT_TIME_RESET;
         buffer_limit_ff <= IRDEC_BUFFER_LIMIT_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_BIT_TIME) begin
            bit_time_ff <= pwdata[15:0];
         end else begin
            buffer_limit_ff <= pwdata[15:0];
         end
      end
   end

   // front end: accept and classify runs into the queue
   irdec_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pulse_flag    (req_pulse_flag),
      .req_duration      (req_duration),
      .req_last_in_burst (req_last_in_burst),
      .q_valid           (q_valid),
      .q_data            (q_data),
      .q_pop             (q_pop)
   );

   // back end: bit count, frame, burst bookkeeping and result beat
   irdec_back u_back (
      .clock            (clock),
      .reset            (reset),
      .bit_time         (bit_time_ff),
      .buffer_limit     (buffer_limit_ff),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_rx_byte      (rsp_rx_byte),
      .rsp_burst_end    (rsp_burst_end),
      .rsp_burst_result (rsp_burst_result),
      .rsp_byte_count   (rsp_byte_count)
   );

endmodule

[src/irdec_checker.sv]
// port-level checker of the run-length decoder and its bind
`include "ir_uart_8o1_run_length_decoder_macros.svh"

module irdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_rx_byte,
   input logic        rsp_burst_end,
   input logic [1:0]  rsp_burst_result,
   input logic [15:0] rsp_byte_count
);
   import irdec_pkg::*;

   // a run that gave no byte carries a zero byte
   `IRDEC_ASSERT_IMPL(a_no_byte_zero, clock, reset, rsp_valid && (rsp_status == STATUS_NONE), rsp_rx_byte == 8'd0, "byte set on a run without a byte")

   // burst result only on the closing beat
   `IRDEC_ASSERT_IMPL(a_result_on_end, clock, reset, rsp_valid && !rsp_burst_end, rsp_burst_result == BURST_OK, "burst result outside burst end")

   // a full burst decodes nothing further
   `IRDEC_ASSERT_IMPL(a_full_quiet, clock, reset, rsp_valid && (rsp_burst_result == BURST_FULL), rsp_status == STATUS_NONE, "byte decoded in a full burst")

   // a stalled result beat holds
   `IRDEC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_rx_byte) && $stable(rsp_byte_count), "stalled result changed")

endmodule

bind ir_uart_8o1_run_length_decoder irdec_checker u_checker (.*);

[tb/testbench.sv]
// self-checking testbench of the run-length 8o1 uart decoder: framed runs, noise and bursts
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import irdec_pkg::*;

   // one run beat as the sender sees it
   typedef struct {
      bit        space;
      bit [23:0] duration;
      bit        last;
   } run_beat_type;

   // one decoded result beat
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  rx_byte;
      logic        burst_end;
      logic [1:0]  burst_result;
      logic [15:0] byte_count;
   } decode_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // run input channel
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic        req_pulse_flag    = 1'b0;
   logic [23:0] req_duration      = '0;
   logic        req_last_in_burst = 1'b0;

   // result channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_burst_end;
   logic [1:0]  rsp_burst_result;
   logic [15:0] rsp_byte_count;

   // register port
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // runs waiting to be sent and decodes waiting to come back
   run_beat_type run_queue[$];
   decode_type   decoded_queue[$];
   int           runs_queued = 0;
   int           fail_count  = 0;

   // handshake bookkeeping between the sampling and driving edges
   bit           run_taken  = 1'b0;
   int           send_gap   = 0;
   int           stall_left = 0;
   bit           no_idle    = 1'b0;
   run_beat_type beat;

   // own copy of the decoder: registers, frame state, burst state
   logic [15:0] cfg_period = IRDEC_BIT_TIME_RESET;
   logic [15:0] cfg_limit  = IRDEC_BUFFER_LIMIT_RESET;
   logic [3:0]  fr_pos     = '0;
   logic [7:0]  shift_reg  = '0;
   logic        parity_acc = 1'b0;
   logic        burst_err  = 1'b0;
   logic        burst_full = 1'b0;
   logic [15:0] burst_cnt  = '0;

   ir_uart_8o1_run_length_decoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pulse_flag    (req_pulse_flag),
      .req_duration      (req_duration),
      .req_last_in_burst (req_last_in_burst),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_burst_end     (rsp_burst_end),
      .rsp_burst_result  (rsp_burst_result),
      .rsp_byte_count    (rsp_byte_count),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #1 clock = ~clock;

   // decode one run: unless the burst is full, round to bit periods, clamp or break, then step the frame
   task automatic decode_run(input bit space, input bit [23:0] dur, input bit last,
                             output decode_type res);
      int unsigned per;
      int unsigned bits;
      bit          is_mark;
      bit          err;
      bit          got;
      logic [7:0]  rx;
      is_mark = !space;
      err     = 1'b0;
      got     = 1'b0;
      rx      = '0;
      res     = '0;
      res.status = STATUS_NONE;
      // at-or-above test also catches a limit lowered mid-burst
      if (!burst_full && burst_cnt >= cfg_limit) burst_full = 1'b1;
      if (!burst_full) begin
         per  = (cfg_period == 0) ? 1 : cfg_period;
         bits = (32'(dur) + per / 2) / per;
         if (bits > 10) begin
            if (is_mark) begin
               bits = 10;
            end else begin
               // break: restart the frame, the run is one start bit
               err        = 1'b1;
               fr_pos     = '0;
               shift_reg  = '0;
               parity_acc = 1'b0;
               bits       = 1;
            end
         end
         repeat (bits) begin
            if (fr_pos == 0) begin
               // marks while waiting for a start bit are idle line
               if (!is_mark) begin
                  fr_pos     = 4'd1;
                  shift_reg  = '0;
                  parity_acc = 1'b0;
               end
            end else if (fr_pos < 9) begin
               fr_pos     = fr_pos + 4'd1;
               shift_reg  = {is_mark, shift_reg[7:1]};
               parity_acc = parity_acc ^ is_mark;
            end else if (fr_pos == 9) begin
               // parity bit: byte is handed out even when parity is wrong
               fr_pos     = 4'd10;
               rx         = shift_reg;
               got        = 1'b1;
               parity_acc = parity_acc ^ is_mark;
               if (!parity_acc) err = 1'b1;
            end else begin
               // stop bit must be a mark
               if (!is_mark) err = 1'b1;
               fr_pos = '0;
            end
         end
         if (err) begin
            res.status = STATUS_ERROR;
            burst_err  = 1'b1;
         end else if (got) begin
            res.status = STATUS_BYTE;
            burst_cnt  = burst_cnt + 16'd1;
         end
      end
      res.rx_byte      = rx;
      res.burst_end    = last;
      res.byte_count   = burst_cnt;
      res.burst_result = BURST_OK;
      if (last) begin
         if (burst_full) res.burst_result = BURST_FULL;
         else if (burst_err) res.burst_result = BURST_ERROR;
         burst_err  = 1'b0;
         burst_full = 1'b0;
         burst_cnt  = '0;
      end
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // duration that rounds to exactly n bits at the current period
   function automatic bit [23:0] run_length(input int unsigned n);
      int unsigned per;
      int unsigned base;
      per  = cfg_period;
      base = n * per;
      if ($urandom_range(0, 3) == 0) return 24'(base);
      return 24'(base - per / 2 + $urandom_range(0, per - 1));
   endfunction

   task automatic push_run(input bit space, input bit [23:0] dur, input bit last);
      run_beat_type b;
      b.space    = space;
      b.duration = dur;
      b.last     = last;
      run_queue.push_back(b);
      runs_queued++;
   endtask

   // one 8o1 frame plus trailing idle marks, merged into level runs
   task automatic queue_frame(input logic [7:0] data, input bit bad_parity,
                              input bit bad_stop, input int idle_bits, input bit last);
      bit levels[$];
      int n;
      levels.push_back(1'b0);
      for (int i = 0; i < 8; i++) levels.push_back(data[i]);
      levels.push_back(~(^data) ^ bad_parity);
      levels.push_back(!bad_stop);
      repeat (idle_bits) levels.push_back(1'b1);
      n = 1;
      for (int i = 1; i <= levels.size(); i++) begin
         if (i < levels.size() && levels[i] == levels[i-1]) begin
            n++;
         end else begin
            // level 1 is a mark, which the pulse flag gives as 0
            push_run(!levels[i-1], run_length(n), last && (i == levels.size()));
            n = 1;
         end
      end
   endtask

   // mostly well-formed frames, the rest noise, breaks and short runs
   task automatic random_runs(input int count);
      int start;
      int r;
      int idle;
      int unsigned short_max;
      start = runs_queued;
      while (runs_queued - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            idle = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 2);
            queue_frame(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 11) == 0,
                        idle, $urandom_range(0, 4) == 0);
         end else if (r < 85) begin
            push_run(1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? 24'($urandom)
                                          : 24'($urandom_range(0, 12 * cfg_period)),
                     $urandom_range(0, 9) == 0);
         end else if (r < 92) begin
            push_run(1'b1, run_length($urandom_range(11, 20)), $urandom_range(0, 3) == 0);
         end else begin
            short_max = (cfg_period >= 2) ? cfg_period / 2 - 1 : 0;
            push_run(1'($urandom_range(0, 1)), 24'($urandom_range(0, short_max)),
                     $urandom_range(0, 5) == 0);
         end
      end
   endtask

   // hold off until every sent run has its result, then let the back end settle
   task automatic wait_drained();
      while (run_queue.size() != 0 || req_valid || decoded_queue.size() != 0)
         @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   // register write, then read back over the same port
   task automatic write_reg(input logic idx, input logic [15:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'h0, val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== val) begin
         $error("register %0d readback expected %0d got %0d", idx, val, prdata[15:0]);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_BIT_TIME:     cfg_period = val;
         REG_BUFFER_LIMIT: cfg_limit  = val;
         default:          ;
      endcase
   endtask

   // random runs with a full pause halfway, closed by a frame that leaves the burst open
   task automatic run_phase(input int count);
      random_runs(count / 2);
      wait_drained();
      random_runs(count - count / 2);
      queue_frame(8'($urandom), 1'b0, 1'b0, 0, 1'b0);
      wait_drained();
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // driver: a new run beat goes out at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || run_taken) begin
         run_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (run_queue.size() != 0) begin
            beat = run_queue.pop_front();
            req_pulse_flag    <= beat.space;
            req_duration      <= beat.duration;
            req_last_in_burst <= beat.last;
            req_valid         <= 1'b1;
            send_gap = no_idle ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern, no new stalls during the back-to-back phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // monitor: predict on each accepted run beat, check each accepted result beat
   always @(posedge clock) begin
      decode_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_run(req_pulse_flag, req_duration, req_last_in_burst, want);
            decoded_queue.push_back(want);
            run_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_queue.size() == 0) begin
               $error("result beat with no run pending");
               fail_count++;
            end else begin
               want = decoded_queue.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("rx_byte", 16'(want.rx_byte), 16'(rsp_rx_byte));
               check_field("burst_end", 16'(want.burst_end), 16'(rsp_burst_end));
               check_field("burst_result", 16'(want.burst_result), 16'(rsp_burst_result));
               check_field("byte_count", want.byte_count, rsp_byte_count);
            end
         end
      end
   end

   // run watchdog
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // stimulus sequence
   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed runs at reset settings
      push_run(1'b0, 24'd0, 1'b0);           // zero-length mark steps nothing
      push_run(1'b1, 24'd208, 1'b0);         // space too short to round to a bit
      push_run(1'b0, 24'hFFFFFF, 1'b0);      // long mark while idle, clamped
      queue_frame(8'h00, 1'b0, 1'b0, 0, 1'b0);
      queue_frame(8'hFF, 1'b0, 1'b0, 0, 1'b0);
      queue_frame(8'h0F, 1'b1, 1'b0, 0, 1'b0); // wrong parity, byte still out
      queue_frame(8'h3C, 1'b0, 1'b1, 1, 1'b0); // space stop bit
      push_run(1'b1, 24'hFFFFFF, 1'b1);      // break closes burst with error
      queue_frame(8'h81, 1'b0, 1'b0, 0, 1'b1); // clean burst after break
      run_phase(90);

      // shortest period, one byte per burst
      write_reg(REG_BIT_TIME, 16'd1);
      write_reg(REG_BUFFER_LIMIT, 16'd1);
      run_phase(70);

      // longest period and largest limit, back to back with no idling
      no_idle = 1'b1;
      write_reg(REG_BIT_TIME, 16'hFFFF);
      write_reg(REG_BUFFER_LIMIT, 16'hFFFF);
      run_phase(90);
      no_idle = 1'b0;

      // limit dropped while a burst is still open
      write_reg(REG_BUFFER_LIMIT, 16'd2);
      write_reg(REG_BIT_TIME, 16'($urandom_range(2, 1000)));
      run_phase(90);

      write_reg(REG_BIT_TIME, 16'($urandom_range(1, 65535)));
      write_reg(REG_BUFFER_LIMIT, 16'($urandom_range(1, 8)));
      run_phase(90);

      write_reg(REG_BIT_TIME, IRDEC_BIT_TIME_RESET);
      write_reg(REG_BUFFER_LIMIT, IRDEC_BUFFER_LIMIT_RESET);
      run_phase(100);

      // settle so a stray extra result would still be caught
      repeat (60) @(posedge clock);
      if (fail_count == 0 && decoded_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[ir_uart_8o1_run_length_decoder.f]
+incdir+src
src/irdec_pkg.sv
src/irdec_front.sv
src/irdec_back.sv
src/ir_uart_8o1_run_length_decoder.sv
src/irdec_checker.sv
tb/testbench.sv
